>>> hdl/double_ended_queue_core_assert.svh
// Assertion macros shared by the double-ended queue RTL.
// Files that use them need clk_i and rst_ni in scope.
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("deque invariant violated");

// Consequence that must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque sequencing violated");

`endif

>>> hdl/deq_pkg.sv
// Shared types and codes for the double-ended queue core.
// No dependencies; imported by every module of the block.
package deq_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_PEEK       = 3'd5
  } deq_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP_BACK,
    CMD_POP_FRONT,
    CMD_CLEAR
  } deq_cmd_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         count;
    deq_status_e        status;
  } deq_out_t;

endpackage

>>> hdl/deq_cell.sv
// One storage cell of the deque chain: a word and its occupied flag.
// Depends on deq_pkg for the command type.
module deq_cell import deq_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  deq_cmd_e         cmd_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic [WIDTH-1:0] left_data_i,
  input  logic             left_valid_i,
  input  logic [WIDTH-1:0] right_data_i,
  input  logic             right_valid_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_d_o,
  output logic             valid_d_o
);

  logic [WIDTH-1:0] data_q, data_d;
  logic             valid_q, valid_d;

  // The cell at the front sees a permanently valid left neighbor and takes
  // the pushed word when the chain shifts toward the back.
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (cmd_i)
      CMD_PUSH_BACK: begin
        if (!valid_q && left_valid_i) begin
          data_d  = push_data_i;
          valid_d = 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      CMD_POP_BACK: begin
        if (valid_q && !right_valid_i) begin
          valid_d = 1'b0;
        end
      end
      CMD_POP_FRONT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      CMD_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign valid_o   = valid_q;
  assign data_d_o  = data_d;
  assign valid_d_o = valid_d;

endmodule

>>> hdl/double_ended_queue_core.sv
// Top level of the double-ended queue: a chain of deq_cell instances plus
// the operation decoder and the result register. Depends on deq_pkg.
//
// Usage: one operation is transferred on the in_* channel (valid/ready) and
// exactly one result comes back on the out_* channel. The deque is a row of
// DEPTH cells; cell 0 always holds the front word and occupied cells are
// packed from cell 0 upward, so a push or pop at the front shifts the whole
// row by one cell, while a push or pop at the back only touches the cell at
// the boundary of the occupied region.
// The result of an operation is registered and is offered on the out
// channel in the cycle after the input transfer. One operation is taken
// per cycle while the receiver does not stall the result register.
// The front and back words of a result come from the next-state values of
// the cells, so they already reflect the operation itself.
// Reset empties the deque at once (only the occupied flags are cleared) and
// drops any pending result. While the receiver stalls, the result register
// holds its contents and in_ready_o stays low, so no operation is lost.
// A pop on an empty deque and a push on a full one change nothing and are
// reported through the status field.
`include "double_ended_queue_core_assert.svh"

module double_ended_queue_core import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  deq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output deq_out_t out_data_o
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] cell_data_q [DEPTH];
  logic [WIDTH-1:0] cell_data_d [DEPTH];
  logic [DEPTH-1:0] cell_valid_q;
  logic [DEPTH-1:0] cell_valid_d;

  logic [CW-1:0]    count_q, count_d, count_nxt;
  logic             out_valid_q;
  deq_out_t         out_data_q;

  logic             in_fire;
  logic             full, empty;
  deq_cmd_e         cmd, cell_cmd;
  deq_status_e      status;
  logic [WIDTH-1:0] push_word;
  logic [WIDTH-1:0] popped_word, back_q_word, back_d_word, front_d_word;

  // A new operation is taken whenever the result register is free or is
  // being emptied in this same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign empty     = !cell_valid_q[0];
  assign full      = cell_valid_q[DEPTH-1];
  assign push_word = WIDTH'(in_data_i.value);

  // Decode the operation. Failed pushes and pops leave the chain on hold.
  always_comb begin
    cmd       = CMD_HOLD;
    status    = ST_OK;
    count_nxt = count_q;
    case (deq_op_e'(in_data_i.op))
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd       = (deq_op_e'(in_data_i.op) == OP_PUSH_BACK) ? CMD_PUSH_BACK
                                                                : CMD_PUSH_FRONT;
          count_nxt = count_q + CW'(1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd       = (deq_op_e'(in_data_i.op) == OP_POP_BACK) ? CMD_POP_BACK
                                                               : CMD_POP_FRONT;
          count_nxt = count_q - CW'(1);
        end
      end
      OP_CLEAR: begin
        cmd       = CMD_CLEAR;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cell_cmd = in_fire ? cmd : CMD_HOLD;
  assign count_d  = in_fire ? count_nxt : count_q;

  // The chain of cells. The front cell sees a valid left neighbor that
  // carries the pushed word; the last cell sees an empty right neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_data, right_data;
    logic             left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = push_word;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data_q[i-1];
      assign left_valid = cell_valid_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data_q[i+1];
      assign right_valid = cell_valid_q[i+1];
    end

    deq_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cell_cmd),
      .push_data_i   (push_word),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data_q[i]),
      .valid_o       (cell_valid_q[i]),
      .data_d_o      (cell_data_d[i]),
      .valid_d_o     (cell_valid_d[i])
    );
  end

  // The back word is the occupied cell whose right neighbor is free. Exactly
  // one such cell exists when the deque is not empty, so an OR-mux suffices.
  always_comb begin
    back_q_word = '0;
    back_d_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid_q[i] && (i == DEPTH - 1 || !cell_valid_q[(i+1) % DEPTH])) begin
        back_q_word = back_q_word | cell_data_q[i];
      end
      if (cell_valid_d[i] && (i == DEPTH - 1 || !cell_valid_d[(i+1) % DEPTH])) begin
        back_d_word = back_d_word | cell_data_d[i];
      end
    end
  end

  assign front_d_word = cell_valid_d[0] ? cell_data_d[0] : '0;

  always_comb begin
    popped_word = '0;
    if (cmd == CMD_POP_BACK) begin
      popped_word = back_q_word;
    end else if (cmd == CMD_POP_FRONT) begin
      popped_word = cell_data_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stored words are sign-extended from WIDTH bits to the 32-bit fields.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.popped_value <= 32'(signed'(popped_word));
      out_data_q.front_value  <= 32'(signed'(front_d_word));
      out_data_q.back_value   <= 32'(signed'(back_d_word));
      out_data_q.count        <= 5'(count_nxt);
      out_data_q.status       <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The occupied flags always form a run from the front of the chain whose
  // length equals the element count.
  `DEQ_ASSERT_ALWAYS(a_count_matches_cells, $countones(cell_valid_q) == count_q)
  `DEQ_ASSERT_ALWAYS(a_front_flag_matches_count, cell_valid_q[0] == (count_q != '0))
  `DEQ_ASSERT_NEXT(a_push_grows,
    in_fire && !full && (in_data_i.op == OP_PUSH_BACK || in_data_i.op == OP_PUSH_FRONT),
    count_q == $past(count_q) + CW'(1))
  `DEQ_ASSERT_NEXT(a_failed_op_holds,
    in_fire && ((full && (in_data_i.op == OP_PUSH_BACK || in_data_i.op == OP_PUSH_FRONT))
             || (empty && (in_data_i.op == OP_POP_BACK || in_data_i.op == OP_POP_FRONT))),
    $stable(cell_valid_q) && $stable(count_q))

endmodule

>>> sim/double_ended_queue_core_test.sv
// Self-checking testbench for the double-ended queue core: directed corner cases, then
// random push/pop traffic under several sender and receiver idling patterns.
// Depends on deq_pkg and on the double_ended_queue_core RTL.
module double_ended_queue_core_test;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam int CYCLE_LIMIT = 400000;

  // Op codes outside the package enum; the block treats them as a peek.
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Shapes of the random traffic.
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  deq_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  deq_out_t out_data_o;

  // Shadow copy of the deque contents, kept in circular form.
  logic [31:0] shadow_store [DEPTH];
  int          shadow_head;
  int          shadow_count;

  deq_out_t pending_results [$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int items_sent;
  int results_checked;
  int full_drops;
  int empty_pops;
  int cycle_count;

  double_ended_queue_core #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Global watchdog. A correct run finishes far below this count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: the ready line is redrawn at every falling edge, so stalls land on
  // any phase of the block's work.
  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_checked, msg);
    mismatches++;
  endtask

  // Applies one operation to the shadow deque and returns the result it must produce.
  // The front and back words reflect the state after the operation.
  function automatic deq_out_t apply_deque_op(input logic [2:0] op, input logic [31:0] word);
    deq_out_t res;
    int slot;
    res = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = (shadow_head + shadow_count) % DEPTH;
          shadow_store[slot] = word;
          shadow_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (shadow_count == DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = word;
          shadow_count++;
        end
      end
      OP_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = (shadow_head + shadow_count - 1) % DEPTH;
          res.popped_value = shadow_store[slot];
          shadow_count--;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.popped_value = shadow_store[shadow_head];
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        shadow_head = 0;
      end
      default: begin
      end
    endcase
    if (shadow_count != 0) begin
      res.front_value = shadow_store[shadow_head];
      res.back_value = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
    end
    res.count = 5'(shadow_count);
    return res;
  endfunction

  // Offers one operation on the input channel, optionally after an idle gap, and
  // records the expected result once the transfer has taken place. Valid stays
  // high afterwards so back-to-back operations need no bubble.
  task automatic send_op(input logic [2:0] op, input logic [31:0] word);
    int gap;
    deq_out_t want;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i.op = op;
    in_data_i.value = word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = apply_deque_op(op, word);
    if (want.status == ST_FULL) full_drops++;
    if (want.status == ST_EMPTY) empty_pops++;
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Lowers valid and holds the sender back until every outstanding result is in.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Compares each result transfer with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    deq_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no operation outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.popped_value !== want.popped_value)
          report_mismatch($sformatf("popped_value %h, expected %h",
                                    out_data_o.popped_value, want.popped_value));
        if (out_data_o.front_value !== want.front_value)
          report_mismatch($sformatf("front_value %h, expected %h",
                                    out_data_o.front_value, want.front_value));
        if (out_data_o.back_value !== want.back_value)
          report_mismatch($sformatf("back_value %h, expected %h",
                                    out_data_o.back_value, want.back_value));
        if (out_data_o.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d",
                                    out_data_o.count, want.count));
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_data_o.status, want.status));
      end
      results_checked++;
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  // Fill traffic leans on pushes so the full condition is reached often, drain traffic
  // leans on pops so the empty condition is, and mixed traffic moves around the middle.
  function automatic logic [2:0] pick_op(input traffic_mode_e mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        if (roll < 40) return OP_PUSH_BACK;
        if (roll < 75) return OP_PUSH_FRONT;
        if (roll < 84) return OP_POP_BACK;
        if (roll < 93) return OP_POP_FRONT;
        if (roll < 96) return OP_PEEK;
        if (roll < 98) return (roll[0] ? OP_UNUSED_LO : OP_UNUSED_HI);
        return OP_CLEAR;
      end
      MODE_DRAIN: begin
        if (roll < 12) return OP_PUSH_BACK;
        if (roll < 24) return OP_PUSH_FRONT;
        if (roll < 55) return OP_POP_BACK;
        if (roll < 88) return OP_POP_FRONT;
        if (roll < 94) return OP_PEEK;
        if (roll < 98) return (roll[0] ? OP_UNUSED_LO : OP_UNUSED_HI);
        return OP_CLEAR;
      end
      default: begin
        if (roll < 24) return OP_PUSH_BACK;
        if (roll < 48) return OP_PUSH_FRONT;
        if (roll < 70) return OP_POP_BACK;
        if (roll < 92) return OP_POP_FRONT;
        if (roll < 95) return OP_PEEK;
        if (roll < 97) return (roll[0] ? OP_UNUSED_LO : OP_UNUSED_HI);
        return OP_CLEAR;
      end
    endcase
  endfunction

  // Empty deque right after reset: peek, pops on empty from both ends.
  task automatic test_empty_after_reset();
    send_op(OP_PEEK, 32'h0);
    send_op(OP_POP_BACK, 32'hdead_beef);
    send_op(OP_POP_FRONT, 32'h1234_5678);
  endtask

  // Extreme words pushed at each end, so the head wraps below zero on the first push.
  task automatic test_extreme_words();
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_PUSH_BACK, 32'h7fff_ffff);
    send_op(OP_PUSH_FRONT, 32'hffff_ffff);
    send_op(OP_PUSH_BACK, 32'h0000_0000);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_FRONT, 32'h0);
  endtask

  // The unused op codes must leave the deque alone and just report it.
  task automatic test_unused_ops();
    send_op(OP_PUSH_BACK, 32'h5a5a_a5a5);
    send_op(OP_UNUSED_LO, 32'hffff_ffff);
    send_op(OP_UNUSED_HI, 32'h0000_0001);
  endtask

  // Clear with entries present, then a pop that must see an empty deque, and a push
  // that must land in a fresh front position.
  task automatic test_clear();
    send_op(OP_PUSH_FRONT, 32'h0bad_cafe);
    send_op(OP_CLEAR, 32'h7fff_ffff);
    send_op(OP_POP_BACK, 32'h0);
    send_op(OP_PUSH_BACK, 32'h8000_0001);
    send_op(OP_CLEAR, 32'h0);
  endtask

  // Random traffic in segments of one shape each; the number of operations is
  // what ends the phase.
  task automatic test_random_traffic(input int n_ops, input int idle_pct, input int stall_pct);
    int done;
    int seg_len;
    traffic_mode_e mode;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < n_ops) begin
      mode = traffic_mode_e'($urandom_range(2));
      seg_len = $urandom_range(10, 50);
      for (int i = 0; i < seg_len && done < n_ops; i++) begin
        send_op(pick_op(mode), pick_word());
        done++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    full_drops = 0;
    empty_pops = 0;
    cycle_count = 0;
    shadow_head = 0;
    shadow_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < DEPTH; i++) shadow_store[i] = '0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_after_reset();
    test_extreme_words();
    test_unused_ops();
    test_clear();
    wait_for_results();

    // The directed part runs at full rate; the random part goes through each
    // idling pattern in turn, draining completely between patterns.
    test_random_traffic(360, 0, 0);
    test_random_traffic(360, 52, 0);
    test_random_traffic(360, 0, 52);
    test_random_traffic(350, 19, 19);

    // The result is registered; give anything stray a chance to show up
    // before the summary.
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);

    $display("covered %0d operations and %0d results, with %0d pushes dropped on full",
             items_sent, results_checked, full_drops);
    $display("and %0d pops on empty, across four idling patterns", empty_pops);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/deq_pkg.sv
hdl/deq_cell.sv
hdl/double_ended_queue_core.sv
sim/double_ended_queue_core_test.sv
